FILE: hdl/rse_pkg.sv
`timescale 1ns / 1ps

package rse_pkg;

  // Default geometry of the code
  localparam int SymbolBitsDef = 8;
  localparam int MaxParityDef  = 32;

  // Configuration register map
  localparam int CountW  = 6;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgPrimPoly    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgParityCount = 2'd1;

  // Register reset values
  localparam int PrimPolyReset    = 285;
  localparam int ParityCountReset = 16;

  // Request to the generator derivation sequencer
  typedef struct packed {
    logic              start;
    logic [CountW-1:0] count;
  } rse_drv_req_t;

endpackage

FILE: hdl/rse_gf_mul.sv
`timescale 1ns / 1ps

module rse_gf_mul #(
  parameter int SYMBOL_BITS = 8
) (
  input  logic [SYMBOL_BITS-1:0] a_i,
  input  logic [SYMBOL_BITS-1:0] b_i,
  input  logic [SYMBOL_BITS-1:0] poly_i,
  output logic [SYMBOL_BITS-1:0] p_o
);

  logic [SYMBOL_BITS-1:0] acc;
  logic [SYMBOL_BITS-1:0] sh;

  // shift-and-add, reducing by the low bits of the polynomial on overflow
  always_comb begin
    acc = '0;
    sh  = a_i;
    for (int i = 0; i < SYMBOL_BITS; i++) begin
      if (b_i[i]) begin
        acc = acc ^ sh;
      end
      sh = {sh[SYMBOL_BITS-2:0], 1'b0} ^ (sh[SYMBOL_BITS-1] ? poly_i : '0);
    end
  end

  assign p_o = acc;

endmodule

FILE: hdl/rse_gen_derive.sv
`timescale 1ns / 1ps

module rse_gen_derive #(
  parameter int SYMBOL_BITS = rse_pkg::SymbolBitsDef,
  parameter int MAX_PARITY  = rse_pkg::MaxParityDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rse_pkg::rse_drv_req_t                   req_i,
  input  logic [SYMBOL_BITS-1:0]                  poly_i,
  output logic                                    busy_o,
  output logic [$clog2(MAX_PARITY+1)-1:0]         n_o,
  output logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0]  coefs_o
);

  import rse_pkg::*;

  localparam int NW = $clog2(MAX_PARITY + 1);

  logic                                 busy_q;
  logic [NW-1:0]                        n_q;
  logic [NW-1:0]                        step_q;
  logic [SYMBOL_BITS-1:0]               root_q;
  logic [SYMBOL_BITS-1:0]               root_d;
  logic [MAX_PARITY:0][SYMBOL_BITS-1:0] g_q;
  logic [MAX_PARITY:0][SYMBOL_BITS-1:0] g_d;
  logic [MAX_PARITY:0][SYMBOL_BITS-1:0] g_init;
  logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] prod;

  // clamp the requested count into one .. MAX_PARITY
  function automatic logic [NW-1:0] sat_count(input logic [CountW-1:0] c);
    logic [NW-1:0] r;
    if (c == '0) begin
      r = NW'(1);
    end else if (int'(c) > MAX_PARITY) begin
      r = NW'(MAX_PARITY);
    end else begin
      r = NW'(c);
    end
    return r;
  endfunction

  always_comb begin
    g_init    = '0;
    g_init[0] = SYMBOL_BITS'(1);
  end

  // one factor (x + root) multiplied in per cycle, all coefficients at once
  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_mul
    rse_gf_mul #(.SYMBOL_BITS(SYMBOL_BITS)) u_mul (
      .a_i    (g_q[j]),
      .b_i    (root_q),
      .poly_i (poly_i),
      .p_o    (prod[j])
    );
  end

  always_comb begin
    g_d[0] = g_q[0];
    for (int j = 1; j <= MAX_PARITY; j++) begin
      g_d[j] = g_q[j] ^ prod[j-1];
    end
  end

  assign root_d = {root_q[SYMBOL_BITS-2:0], 1'b0} ^ (root_q[SYMBOL_BITS-1] ? poly_i : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      n_q    <= sat_count(CountW'(ParityCountReset));
      step_q <= '0;
      root_q <= SYMBOL_BITS'(1);
      g_q    <= g_init;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      n_q    <= sat_count(req_i.count);
      step_q <= '0;
      root_q <= SYMBOL_BITS'(1);
      g_q    <= g_init;
    end else if (busy_q) begin
      g_q    <= g_d;
      root_q <= root_d;
      step_q <= step_q + NW'(1);
      if (step_q == n_q - NW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign n_o    = n_q;

  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_out
    assign coefs_o[j] = g_q[j+1];
  end

endmodule

FILE: hdl/rs_systematic_encoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Word
// in        sink       in_valid_i / in_ready_o    data_symbol_i, last_data_i
// out       source     out_valid_o / out_ready_i  out_symbol_o, is_parity_o, last_out_o
// cfg       sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Data words pass at one a cycle unless held off; a word flagged last is followed
// by n parity words, one a cycle while the buffer has room, with input held off
// (n = clamped parity count). After reset and after every configuration write,
// the generator sequencer multiplies in one root a cycle; input waits until it
// is done. A two-word output buffer decouples the sides; a stalled output holds
// the input off only once both entries are full. Configuration is always taken.

module rs_systematic_encoder #(
  parameter int SYMBOL_BITS = rse_pkg::SymbolBitsDef,
  parameter int MAX_PARITY  = rse_pkg::MaxParityDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [SYMBOL_BITS-1:0]                 data_symbol_i,
  input  logic                                   last_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [SYMBOL_BITS-1:0]                 out_symbol_o,
  output logic                                   is_parity_o,
  output logic                                   last_out_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rse_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [((SYMBOL_BITS + 1 > rse_pkg::CountW) ?
                 SYMBOL_BITS + 1 : rse_pkg::CountW)-1:0] cfg_data_i
);

  import rse_pkg::*;

  localparam int NW    = $clog2(MAX_PARITY + 1);
  localparam int PolyW = SYMBOL_BITS + 1;

  // Configuration registers
  logic [PolyW-1:0]  poly_q;
  logic [CountW-1:0] count_q;
  logic              start_q;
  logic              cfg_acc;

  // Generator sequencer
  rse_drv_req_t                          drv_req;
  logic                                  drv_busy;
  logic [NW-1:0]                         drv_n;
  logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] drv_coefs;

  // Message state and division register
  logic                                   msg_q;
  logic                                   emit_q;
  logic [NW-1:0]                          emit_left_q;
  logic [NW-1:0]                          act_n_q;
  logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] act_gen_q;
  logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] par_q;
  logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] par_up;
  logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] gen_use;
  logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] prod;
  logic [NW-1:0]                          n_use;
  logic [SYMBOL_BITS-1:0]                 fb;
  logic                                   in_acc;

  // Output buffer
  logic [SYMBOL_BITS-1:0] buf_sym_q  [2];
  logic                   buf_par_q  [2];
  logic                   buf_last_q [2];
  logic                   wr_ptr_q;
  logic                   rd_ptr_q;
  logic [1:0]             cnt_q;
  logic                   room;
  logic                   push;
  logic                   pop;
  logic [SYMBOL_BITS-1:0] push_sym;
  logic                   push_par;
  logic                   push_last;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // Take register writes at once; kick the sequencer in the cycle after, so it
  // sees the new values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= PolyW'(PrimPolyReset);
      count_q <= CountW'(ParityCountReset);
      start_q <= 1'b0;
    end else begin
      start_q <= cfg_acc;
      if (cfg_acc) begin
        case (cfg_index_i)
          CfgPrimPoly:    poly_q  <= cfg_data_i[PolyW-1:0];
          CfgParityCount: count_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign drv_req.start = start_q;
  assign drv_req.count = count_q;

  rse_gen_derive #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .MAX_PARITY  (MAX_PARITY)
  ) u_derive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (drv_req),
    .poly_i  (poly_q[SYMBOL_BITS-1:0]),
    .busy_o  (drv_busy),
    .n_o     (drv_n),
    .coefs_o (drv_coefs)
  );

  // Hold input off while the generator is rebuilt, parity drains or the buffer is full
  assign room       = (cnt_q != 2'd2);
  assign in_ready_o = !start_q && !drv_busy && !emit_q && room;
  assign in_acc     = in_valid_i && in_ready_o;

  // The first word of a message adopts the freshly derived generator; later
  // words keep the one latched then, whatever is written meanwhile
  assign gen_use = msg_q ? act_gen_q : drv_coefs;
  assign n_use   = msg_q ? act_n_q : drv_n;
  assign fb      = data_symbol_i ^ par_q[0];

  // Division step: every remainder register updates in parallel. Entries at
  // and beyond the active count have zero coefficients and stay clear.
  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_lfsr
    rse_gf_mul #(.SYMBOL_BITS(SYMBOL_BITS)) u_mul (
      .a_i    (gen_use[j]),
      .b_i    (fb),
      .poly_i (poly_q[SYMBOL_BITS-1:0]),
      .p_o    (prod[j])
    );
    if (j == MAX_PARITY - 1) begin : g_top
      assign par_up[j] = '0;
    end else begin : g_mid
      assign par_up[j] = par_q[j+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_q       <= 1'b0;
      emit_q      <= 1'b0;
      emit_left_q <= '0;
      act_n_q     <= '0;
      act_gen_q   <= '0;
      par_q       <= '0;
    end else if (in_acc) begin
      for (int j = 0; j < MAX_PARITY; j++) begin
        par_q[j] <= par_up[j] ^ prod[j];
      end
      if (!msg_q) begin
        act_gen_q <= drv_coefs;
        act_n_q   <= drv_n;
      end
      if (last_data_i) begin
        msg_q       <= 1'b0;
        emit_q      <= 1'b1;
        emit_left_q <= n_use;
      end else begin
        msg_q <= 1'b1;
      end
    end else if (emit_q && room) begin
      // shift the remainder out highest first; zeros fill in behind
      par_q       <= par_up;
      emit_left_q <= emit_left_q - NW'(1);
      if (emit_left_q == NW'(1)) begin
        emit_q <= 1'b0;
      end
    end
  end

  // Output buffer feed: the data word on accept, else a parity word
  assign push      = in_acc || (emit_q && room);
  assign push_sym  = in_acc ? data_symbol_i : par_q[0];
  assign push_par  = !in_acc;
  assign push_last = !in_acc && (emit_left_q == NW'(1));
  assign pop       = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_sym_q[wr_ptr_q]  <= push_sym;
      buf_par_q[wr_ptr_q]  <= push_par;
      buf_last_q[wr_ptr_q] <= push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid_o  = (cnt_q != 2'd0);
  assign out_symbol_o = buf_sym_q[rd_ptr_q];
  assign is_parity_o  = buf_par_q[rd_ptr_q];
  assign last_out_o   = buf_last_q[rd_ptr_q];

  // Checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  a_last_is_parity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_out_o |-> is_parity_o)
    else $error("codeword end flagged on a data word");

  a_emit_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_data_i |=> emit_q && !msg_q)
    else $error("parity drain did not start after the last data word");

  a_emit_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> emit_left_q != '0)
    else $error("parity drain running with nothing left");

  a_no_input_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> !in_acc)
    else $error("data word taken during parity drain");

endmodule

FILE: bench/rs_systematic_encoder_tb.sv
`timescale 1ns / 1ps

// Systematic Reed-Solomon encoder bench. A predictor in this module mirrors
// the field arithmetic, the generator build and the division register, and
// queues the words that each accepted data word must produce. A checker pops
// that queue on every accepted output word and compares it field by field.
module rs_systematic_encoder_tb;
  import rse_pkg::*;

  localparam int SymW      = SymbolBitsDef;
  localparam int MaxPar    = MaxParityDef;
  localparam int CfgDataW  = (SymW + 1 > CountW) ? SymW + 1 : CountW;
  localparam int ClkPeriod = 12;
  localparam int RstCycles = 9;
  // Long receiver hold-off, well beyond what the two-word buffer can absorb
  localparam int LongHold  = 200;
  // Worst quiet stretch: long hold-off, generator rebuild and the longest
  // sender gap, taken many times over
  localparam int WatchdogLimit = 4000;
  // Cycles to watch for stray words once nothing is expected
  localparam int TailCycles    = 60;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            parity;
    logic            tail;
  } code_word_t;

  // DUT ports, all known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [SymW-1:0]     data_symbol_i = '0;
  logic                last_data_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [SymW-1:0]     out_symbol_o;
  logic                is_parity_o;
  logic                last_out_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = CfgPrimPoly;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Shadow of the encoder state kept by the predictor
  logic [8:0]        shadow_poly  = 9'(PrimPolyReset);
  logic [CountW-1:0] shadow_count = CountW'(ParityCountReset);
  logic [SymW-1:0]   remainder_q [MaxPar];
  logic [SymW-1:0]   gen_coef    [MaxPar];
  bit                msg_open = 1'b0;
  int                n_in_use;

  code_word_t pending_words[$];

  // Bench control shared between the processes
  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  bit tx_offering   = 1'b0;
  bit long_hold_req = 1'b0;

  int mismatch_count = 0;
  int symbols_in     = 0;
  int words_out      = 0;
  int codewords_done = 0;
  int settings_done  = 0;
  int long_holds     = 0;
  int quiet_cycles   = 0;

  rs_systematic_encoder #(
    .SYMBOL_BITS(SymW),
    .MAX_PARITY (MaxPar)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_symbol_i(data_symbol_i),
    .last_data_i  (last_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_symbol_o (out_symbol_o),
    .is_parity_o  (is_parity_o),
    .last_out_o   (last_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin : clock_gen
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Shift-and-add multiply; the x^M term is implied, only the low bits of
  // the polynomial pick the reduction, whatever polynomial is loaded
  function automatic logic [SymW-1:0] gf_times(input logic [SymW-1:0] x,
                                               input logic [SymW-1:0] y);
    logic [SymW-1:0] acc;
    logic [SymW-1:0] red;
    acc = '0;
    red = shadow_poly[SymW-1:0];
    for (int i = 0; i < SymW; i++) begin
      if (y[i]) acc ^= x;
      x = x[SymW-1] ? ({x[SymW-2:0], 1'b0} ^ red) : {x[SymW-2:0], 1'b0};
    end
    return acc;
  endfunction

  // Multiply out (x + alpha^i) for the clamped count; zero counts as one,
  // anything past the maximum saturates
  function automatic void build_generator();
    logic [SymW-1:0] g [MaxPar+1];
    logic [SymW-1:0] root;
    int n;
    n = int'(shadow_count);
    if (n < 1) n = 1;
    if (n > MaxPar) n = MaxPar;
    n_in_use = n;
    foreach (g[j]) g[j] = '0;
    g[0] = SymW'(1);
    root = SymW'(1);
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j >= 1; j--) g[j] ^= gf_times(g[j-1], root);
      root = gf_times(root, SymW'(2));
    end
    for (int j = 0; j < MaxPar; j++) gen_coef[j] = (j < n) ? g[j+1] : '0;
  endfunction

  // Advance the division register by one data word and queue what it emits
  function automatic void encode_symbol(input logic [SymW-1:0] sym, input logic fin);
    logic [SymW-1:0] fb;
    code_word_t      w;
    if (!msg_open) begin
      build_generator();
      msg_open = 1'b1;
    end
    w = '{sym: sym, parity: 1'b0, tail: 1'b0};
    pending_words.insert(pending_words.size(), w);
    fb = sym ^ remainder_q[0];
    for (int j = 0; j + 1 < n_in_use; j++)
      remainder_q[j] = remainder_q[j+1] ^ gf_times(gen_coef[j], fb);
    remainder_q[n_in_use-1] = gf_times(gen_coef[n_in_use-1], fb);
    if (fin) begin
      // Emit the remainder, highest coefficient first, and clear it
      for (int j = 0; j < n_in_use; j++) begin
        w = '{sym: remainder_q[j], parity: 1'b1, tail: (j == n_in_use - 1)};
        pending_words.insert(pending_words.size(), w);
      end
      foreach (remainder_q[j]) remainder_q[j] = '0;
      msg_open = 1'b0;
      codewords_done++;
    end
  endfunction

  initial begin : clear_remainder
    foreach (remainder_q[j]) remainder_q[j] = '0;
    build_generator();
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one data word; keep valid high across back-to-back words
  task automatic send_symbol(input logic [SymW-1:0] sym, input logic fin);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      if (tx_offering) begin
        in_valid_i  <= 1'b0;
        tx_offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_symbol_i <= sym;
    last_data_i   <= fin;
    tx_offering   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    symbols_in++;
    encode_symbol(sym, fin);
  endtask

  // One message of random content, extremes now and then
  task automatic send_message(input int len);
    logic [SymW-1:0] sym;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0:       sym = '0;
        1:       sym = '1;
        default: sym = SymW'($urandom_range(0, (1 << SymW) - 1));
      endcase
      send_symbol(sym, k == len - 1);
    end
  endtask

  // Drop valid and hold until every expected word has come out
  task automatic wait_codewords_done();
    if (tx_offering) begin
      in_valid_i  <= 1'b0;
      tx_offering = 1'b0;
    end
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  // Write both registers back to back; only ever called with the block idle
  task automatic configure(input logic [8:0] poly, input logic [CountW-1:0] count);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgPrimPoly;
    cfg_data_i  <= CfgDataW'(poly);
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_poly = poly;
    cfg_index_i <= CfgParityCount;
    cfg_data_i  <= CfgDataW'(count);
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_count = count;
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin : rx_side
    int stall_left;
    int gap;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds++;
        stall_left    = LongHold - 1;
        out_ready_i   <= 1'b0;
      end else begin
        gap = rx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
          stall_left  = gap - 1;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: compare each accepted word with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    code_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (pending_words.size() == 0) begin
        $error("stray word: out_symbol %0h is_parity %0b last_out %0b",
               out_symbol_o, is_parity_o, last_out_o);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_symbol_o !== want.sym) begin
          $error("out_symbol: expected %0h, got %0h", want.sym, out_symbol_o);
          mismatch_count++;
        end
        if (is_parity_o !== want.parity) begin
          $error("is_parity: expected %0b, got %0b", want.parity, is_parity_o);
          mismatch_count++;
        end
        if (last_out_o !== want.tail) begin
          $error("last_out: expected %0b, got %0b", want.tail, last_out_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $error("no word moved for %0d cycles", WatchdogLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset settings: one-word message, all-zero message, edge values
  task automatic test_reset_config();
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h00, 1'b1);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'h7F, 1'b1);
    wait_codewords_done();
  endtask

  // Register extremes and the odd settings: zero and oversized counts,
  // a polynomial missing its top bit and non-primitive polynomials
  task automatic test_register_extremes();
    configure(9'd257, 6'd1);
    send_symbol(8'hA5, 1'b0);
    send_symbol(8'h5A, 1'b1);
    wait_codewords_done();
    configure(9'd511, 6'd32);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b1);
    wait_codewords_done();
    configure(9'd285, 6'd0);
    send_symbol(8'h3C, 1'b1);
    wait_codewords_done();
    configure(9'd285, 6'd63);
    send_symbol(8'hC3, 1'b0);
    send_symbol(8'h81, 1'b1);
    wait_codewords_done();
    configure(9'h01D, 6'd4);
    send_symbol(8'hE1, 1'b0);
    send_symbol(8'h1E, 1'b1);
    wait_codewords_done();
    configure(9'h100, 6'd6);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFE, 1'b1);
    wait_codewords_done();
    configure(9'h1AA, 6'd3);
    send_symbol(8'h55, 1'b1);
    wait_codewords_done();
  endtask

  // Random settings per phase, random messages, idling switched per phase
  task automatic test_random_messages();
    logic [8:0]        poly;
    logic [CountW-1:0] count;
    int                sent_here;
    int                len;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 9))
        0:       poly = 9'(PrimPolyReset);
        1:       poly = ($urandom_range(0, 1) != 0) ? 9'd511 : 9'd257;
        2:       poly = 9'($urandom_range(0, 511));
        default: poly = 9'($urandom_range(257, 511));
      endcase
      case ($urandom_range(0, 19))
        0:       count = '0;
        1:       count = 6'd32;
        2:       count = 6'($urandom_range(33, 63));
        3, 4, 5: count = 6'($urandom_range(9, 32));
        default: count = 6'($urandom_range(1, 8));
      endcase
      configure(poly, count);
      tx_idle_en = (p % 3) != 0;
      rx_idle_en = (p % 4) != 1;
      sent_here  = 0;
      while (sent_here < 16) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        send_message(len);
        sent_here += len;
      end
      wait_codewords_done();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering, so the buffer fills and the input is stalled
  task automatic test_output_backpressure();
    configure(9'd285, 6'd32);
    tx_idle_en    = 1'b0;
    long_hold_req = 1'b1;
    while (long_hold_req) @(posedge clk_i);
    send_message(12);
    send_message(8);
    tx_idle_en = 1'b1;
    wait_codewords_done();
  endtask

  // Full-rate streaming on both sides
  task automatic test_full_rate_stream();
    int sent_here;
    int len;
    configure(9'($urandom_range(257, 511)), 6'($urandom_range(1, 16)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    sent_here  = 0;
    while (sent_here < 60) begin
      len = $urandom_range(1, 8);
      send_message(len);
      sent_here += len;
    end
    wait_codewords_done();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin : run_tests
    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_config();
    test_register_extremes();
    test_random_messages();
    test_output_backpressure();
    test_full_rate_stream();

    wait_codewords_done();
    // Watch for stray words once the pipeline ought to be empty
    repeat (TailCycles) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      mismatch_count++;
    end

    $display("Run covered %0d codewords from %0d data words, %0d output words checked,",
             codewords_done, symbols_in, words_out);
    $display("%0d register settings, %0d long output hold-off(s), %0d mismatches.",
             settings_done, long_holds, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
